[design/double_ended_queue_core_assert.svh]
// Assertion helpers for the deque core.
// Expect clk and rst_n in scope.
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// Clocked property, off while reset is asserted.
`define DEQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must also hold through reset.
`define DEQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/deq_pkg.sv]
package deq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int MODE_W  = 3;
    localparam int FIELD_W = 32;
    localparam int POS_W   = 4;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 5;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ_FRONT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ_BACK  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_READ_INDEX = 3'd6;
    localparam logic [MODE_W-1:0] MODE_FLUSH      = 3'd7;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [FIELD_W-1:0] data_in;
        logic [POS_W-1:0]   position;
    } deq_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [FIELD_W-1:0] data_out;
        logic [OCC_W-1:0]   occupancy;
    } deq_rsp_t;

    // Shift commands broadcast to every cell of the row.
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
    } deq_cmd_t;

endpackage

[design/deq_cell.sv]
module deq_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 5,
    parameter int IDX        = 0
) (
    input  logic                  clk,
    input  deq_pkg::deq_cmd_t     cmd,
    input  logic [CNT_W-1:0]      count,
    input  logic [DATA_WIDTH-1:0] word,
    input  logic [DATA_WIDTH-1:0] left_word,
    input  logic [DATA_WIDTH-1:0] right_word,
    output logic [DATA_WIDTH-1:0] value
);
    import deq_pkg::*;

    logic [DATA_WIDTH-1:0] value_reg;
    logic [DATA_WIDTH-1:0] value_next;

    // left_word is the new word for cell 0; the last cell sees itself on its right
    always_comb
    begin
        value_next = value_reg;
        if (cmd.push_front)
        begin
            value_next = left_word;
        end
        else if (cmd.push_back && (count == CNT_W'(IDX)))
        begin
            value_next = word;
        end
        else if (cmd.pop_front)
        begin
            value_next = right_word;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

[design/deq_read.sv]
module deq_read #(
    parameter int DATA_WIDTH = 32,
    parameter int DEPTH      = 16,
    parameter int CNT_W      = 5,
    parameter int OFF_W      = 5
) (
    input  logic [deq_pkg::MODE_W-1:0] mode,
    input  logic [CNT_W-1:0]           count,
    input  logic [deq_pkg::POS_W-1:0]  position,
    input  logic [DATA_WIDTH-1:0]      cells [DEPTH],
    output logic [DATA_WIDTH-1:0]      word
);
    import deq_pkg::*;

    logic [OFF_W-1:0] offset;

    always_comb
    begin
        case (mode)
            MODE_READ_BACK:  offset = OFF_W'(count) - OFF_W'(1);
            MODE_READ_INDEX: offset = OFF_W'(position);
            default:         offset = '0;
        endcase
    end

    // AND-OR select across the row
    always_comb
    begin
        word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (offset == OFF_W'(i))
            begin
                word = word | cells[i];
            end
        end
    end

endmodule

[design/double_ended_queue_core.sv]
// Double-ended queue core.
// Request channel: present req (mode, data_in, position) with start; the
// transaction is taken on a clock edge where start is high and busy is low.
// busy is always low, so one transaction can be issued every cycle.
// Response channel: rsp (status, data_out, occupancy) is valid for exactly one
// cycle while done is high; it is registered, so it appears in the cycle after the request edge. The receiver
// cannot stall, so it must sample rsp whenever done is seen.
// Throughput: 1 transaction per cycle, set by the row of
// shift cells updating together and the read select over the row.
// Storage is a row of DEPTH cells with the front entry always in cell 0:
// push front shifts the row up, pop front shifts it down, push back loads
// the cell at the current count, pop back only drops the count.
// Reset clears the count and the response strobe; cell contents are left
// as they are and are never read before a push writes them.
`include "double_ended_queue_core_assert.svh"

module double_ended_queue_core #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  deq_pkg::deq_req_t req,
    output logic              done,
    output deq_pkg::deq_rsp_t rsp
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OFF_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic                  fire;
    logic [DATA_WIDTH-1:0] word;
    logic [DATA_WIDTH-1:0] cells [DEPTH];
    logic [DATA_WIDTH-1:0] rd_word;
    logic                  full;
    logic                  empty;
    logic                  idx_bad;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    deq_cmd_t              cmd;
    logic [STAT_W-1:0]     status;
    logic                  rd_en;

    logic                  done_reg;
    deq_rsp_t              rsp_reg;
    deq_rsp_t              rsp_next;

    // No multi-cycle work: never stalls the requester.
    assign busy = 1'b0;
    assign fire = start && !busy;

    // keep the low DATA_WIDTH bits of the incoming word
    assign word  = DATA_WIDTH'(req.data_in);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign idx_bad = (OFF_W'(req.position) >= OFF_W'(count_reg));

    // Operation decode; errors leave the state untouched.
    always_comb
    begin
        count_next = count_reg;
        cmd        = '0;
        status     = ST_OK;
        rd_en      = 1'b0;
        case (req.mode)
            MODE_PUSH_FRONT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    cmd.push_front = fire;
                    count_next     = count_reg + CNT_W'(1);
                end
            end
            MODE_PUSH_BACK:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    cmd.push_back = fire;
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            MODE_POP_FRONT:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    cmd.pop_front = fire;
                    count_next    = count_reg - CNT_W'(1);
                end
            end
            MODE_POP_BACK:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            MODE_READ_FRONT, MODE_READ_BACK:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    rd_en = 1'b1;
                end
            end
            MODE_READ_INDEX:
            begin
                if (idx_bad)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    rd_en = 1'b1;
                end
            end
            default:
            begin
                // flush
                count_next = '0;
            end
        endcase
    end

    // Row of cells; each takes a neighbor's word on a front push or pop, or the new word on a back push at its index.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;

        if (i == 0)
        begin : g_head
            assign left_w = word;
        end
        else
        begin : g_mid
            assign left_w = cells[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_w = cells[i];
        end
        else
        begin : g_body
            assign right_w = cells[i+1];
        end

        deq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .IDX        (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .count      (count_reg),
            .word       (word),
            .left_word  (left_w),
            .right_word (right_w),
            .value      (cells[i])
        );
    end

    deq_read #(
        .DATA_WIDTH (DATA_WIDTH),
        .DEPTH      (DEPTH),
        .CNT_W      (CNT_W),
        .OFF_W      (OFF_W)
    ) u_read (
        .mode     (req.mode),
        .count    (count_reg),
        .position (req.position),
        .cells    (cells),
        .word     (rd_word)
    );

    always_comb
    begin
        rsp_next.status    = status;
        rsp_next.data_out  = rd_en ? FIELD_W'(rd_word) : '0;
        rsp_next.occupancy = OCC_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= fire;
            if (fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    // response payload needs no reset; qualified by done
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    `DEQ_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "count above depth")
    `DEQ_ASSERT(a_one_rsp, fire |=> done, "accepted transaction gave no response")
    `DEQ_ASSERT(a_full_keeps, (fire && full && (req.mode == MODE_PUSH_FRONT || req.mode == MODE_PUSH_BACK)) |=> (count_reg == CNT_W'(DEPTH) && rsp.status == ST_FULL), "push into full queue changed count")
    `DEQ_ASSERT(a_flush, (fire && req.mode == MODE_FLUSH) |=> (count_reg == '0 && rsp.status == ST_OK), "flush did not empty queue")
    `DEQ_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")

endmodule

[dv/double_ended_queue_core_tb.sv]
module double_ended_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    localparam int QDEPTH      = DEPTH_DEF;
    localparam int RANDOM_TXNS = 1100;
    // Hang guard.
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_LIMIT = 100;

    // Traffic mix for one burst of random transactions.
    typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN } traffic_mix_t;

    // One row of the directed sequence. reps > 1 repeats the row with fresh
    // random data; typed rows carry an expected response written out by hand.
    typedef struct {
        deq_req_t   cmd;
        int         reps;
        bit         typed;
        deq_rsp_t   want;
    } deq_row_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    deq_req_t req;
    logic     done;
    deq_rsp_t rsp;

    // Shadow deque: ring of words, front pointer, entry count.
    logic [FIELD_W-1:0] ring_words [QDEPTH];
    logic [POS_W-1:0]   ring_front;
    logic [OCC_W-1:0]   ring_count;

    deq_rsp_t pending_rsp[$];   // responses owed by the DUT, oldest first
    deq_row_t directed_rows[$];
    int       fail_count;
    int       cycle_count;

    double_ended_queue_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Timeout watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Apply one transaction to the shadow deque and return its response.
    function automatic deq_rsp_t deque_step(deq_req_t t);
        deq_rsp_t   o;
        logic [POS_W-1:0] slot;
        o = '0;
        o.status = ST_OK;
        case (t.mode)
            MODE_PUSH_FRONT:
                if (ring_count >= OCC_W'(QDEPTH))
                    o.status = ST_FULL;
                else
                begin
                    ring_front = ring_front - 1'b1;
                    ring_words[ring_front] = t.data_in;
                    ring_count = ring_count + 1'b1;
                end
            MODE_PUSH_BACK:
                if (ring_count >= OCC_W'(QDEPTH))
                    o.status = ST_FULL;
                else
                begin
                    slot = ring_front + POS_W'(ring_count);
                    ring_words[slot] = t.data_in;
                    ring_count = ring_count + 1'b1;
                end
            MODE_POP_FRONT:
                if (ring_count == '0)
                    o.status = ST_EMPTY;
                else
                begin
                    ring_front = ring_front + 1'b1;
                    ring_count = ring_count - 1'b1;
                end
            MODE_POP_BACK:
                if (ring_count == '0)
                    o.status = ST_EMPTY;
                else
                    ring_count = ring_count - 1'b1;
            MODE_READ_FRONT:
                if (ring_count == '0)
                    o.status = ST_EMPTY;
                else
                    o.data_out = ring_words[ring_front];
            MODE_READ_BACK:
                if (ring_count == '0)
                    o.status = ST_EMPTY;
                else
                begin
                    slot = ring_front + POS_W'(ring_count - 1'b1);
                    o.data_out = ring_words[slot];
                end
            MODE_READ_INDEX:
                if ({1'b0, t.position} >= ring_count)
                    o.status = ST_EMPTY;
                else
                begin
                    slot = ring_front + t.position;
                    o.data_out = ring_words[slot];
                end
            default:
            begin
                // flush: ok even when already empty
                ring_count = '0;
                ring_front = '0;
            end
        endcase
        o.occupancy = ring_count;
        return o;
    endfunction

    function automatic void add_row(logic [MODE_W-1:0] m, logic [FIELD_W-1:0] d,
                                    logic [POS_W-1:0] p, int reps, bit typed,
                                    logic [STAT_W-1:0] st, logic [FIELD_W-1:0] dout,
                                    logic [OCC_W-1:0] occ);
        deq_row_t row;
        row.cmd.mode       = m;
        row.cmd.data_in    = d;
        row.cmd.position   = p;
        row.reps           = reps;
        row.typed          = typed;
        row.want.status    = st;
        row.want.data_out  = dout;
        row.want.occupancy = occ;
        directed_rows.push_back(row);
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Data: corner words now and then, otherwise random.
    function automatic logic [FIELD_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        else if (r < 16)
            return '1;
        else
            return $urandom();
    endfunction

    // Mode choice biased by the burst mix so the queue swings between
    // empty and full instead of hovering in the middle.
    function automatic logic [MODE_W-1:0] pick_mode(traffic_mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return MODE_FLUSH;
        case (mix)
            MIX_FILL:
                if (r < 63)
                    return (r[0] ? MODE_PUSH_BACK : MODE_PUSH_FRONT);
                else if (r < 88)
                    return MODE_W'($urandom_range(4, 6));
                else
                    return (r[0] ? MODE_POP_BACK : MODE_POP_FRONT);
            MIX_DRAIN:
                if (r < 63)
                    return (r[0] ? MODE_POP_BACK : MODE_POP_FRONT);
                else if (r < 85)
                    return MODE_W'($urandom_range(4, 6));
                else
                    return (r[0] ? MODE_PUSH_BACK : MODE_PUSH_FRONT);
            default:
                return MODE_W'($urandom_range(0, 6));
        endcase
    endfunction

    // Present one transaction and hold it until taken. The expectation is
    // queued at the accepting edge; start is left high for a following
    // back-to-back transaction.
    task automatic issue(input deq_req_t t, input bit typed, input deq_rsp_t want);
        deq_rsp_t model;
        start <= 1'b1;
        req   <= t;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        model = deque_step(t);
        pending_rsp.push_back(typed ? want : model);
    endtask

    // Idle the request side for a random number of cycles.
    task automatic idle_gap(input bit allow);
        int g;
        g = allow ? pick_gap() : 0;
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Response checker: done has no backpressure, so every strobe must match
    // the oldest pending expectation.
    always @(posedge clk)
    begin
        deq_rsp_t exp_rsp;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response with no transaction outstanding: %p", rsp);
                fail_count++;
            end
            else
            begin
                exp_rsp = pending_rsp.pop_front();
                if (rsp.status !== exp_rsp.status)
                begin
                    $error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
                    fail_count++;
                end
                if (rsp.data_out !== exp_rsp.data_out)
                begin
                    $error("data_out: expected 0x%08h, got 0x%08h",
                           exp_rsp.data_out, rsp.data_out);
                    fail_count++;
                end
                if (rsp.occupancy !== exp_rsp.occupancy)
                begin
                    $error("occupancy: expected %0d, got %0d",
                           exp_rsp.occupancy, rsp.occupancy);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        deq_req_t     t;
        deq_rsp_t     none;
        traffic_mix_t mix;
        int           burst_left;
        bit           gaps_on;
        int           waited;

        fail_count  = 0;
        cycle_count = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        none        = '0;
        ring_front  = '0;
        ring_count  = '0;

        // --- directed sequence ---
        // empty queue: every pop/read errors, flush is still ok
        add_row(MODE_READ_FRONT, '0, '0, 1, 1, ST_EMPTY, '0, 5'd0);
        add_row(MODE_READ_BACK,  '0, '0, 1, 1, ST_EMPTY, '0, 5'd0);
        add_row(MODE_READ_INDEX, '0, '0, 1, 1, ST_EMPTY, '0, 5'd0);
        add_row(MODE_POP_FRONT,  '0, '0, 1, 1, ST_EMPTY, '0, 5'd0);
        add_row(MODE_POP_BACK,   '0, '0, 1, 1, ST_EMPTY, '0, 5'd0);
        add_row(MODE_FLUSH,      '0, '0, 1, 1, ST_OK,    '0, 5'd0);
        // extreme data words, index past the count
        add_row(MODE_PUSH_FRONT, '0, '1, 1, 1, ST_OK, '0, 5'd1);
        add_row(MODE_PUSH_BACK,  '1, '0, 1, 1, ST_OK, '0, 5'd2);
        add_row(MODE_READ_INDEX, '0, 4'd15, 1, 1, ST_EMPTY, '0, 5'd2);
        add_row(MODE_READ_BACK,  '0, '0, 1, 1, ST_OK, '1, 5'd2);
        // fill to full from both ends, front pointer wraps
        add_row(MODE_PUSH_FRONT, '0, '0, 7, 0, '0, '0, '0);
        add_row(MODE_PUSH_BACK,  '0, '0, 7, 0, '0, '0, '0);
        add_row(MODE_PUSH_FRONT, '1, '0, 1, 1, ST_FULL, '0, 5'd16);
        add_row(MODE_PUSH_BACK,  '1, '0, 1, 1, ST_FULL, '0, 5'd16);
        add_row(MODE_READ_INDEX, '0, 4'd15, 1, 0, '0, '0, '0);
        add_row(MODE_READ_FRONT, '0, '0, 1, 0, '0, '0, '0);
        add_row(MODE_POP_FRONT,  '0, '0, 1, 1, ST_OK, '0, 5'd15);
        add_row(MODE_POP_BACK,   '0, '0, 1, 1, ST_OK, '0, 5'd14);
        add_row(MODE_FLUSH,      '0, '0, 1, 1, ST_OK, '0, 5'd0);
        // last entry popped from either end leaves a clean empty queue
        add_row(MODE_PUSH_BACK,  32'h5A5A_A5A5, '0, 1, 1, ST_OK, '0, 5'd1);
        add_row(MODE_POP_FRONT,  '0, '0, 1, 1, ST_OK, '0, 5'd0);
        add_row(MODE_PUSH_FRONT, 32'hA5A5_5A5A, '0, 1, 1, ST_OK, '0, 5'd1);
        add_row(MODE_POP_BACK,   '0, '0, 1, 1, ST_OK, '0, 5'd0);
        add_row(MODE_READ_FRONT, '0, '0, 1, 1, ST_EMPTY, '0, 5'd0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            for (int k = 0; k < directed_rows[i].reps; k++)
            begin
                t = directed_rows[i].cmd;
                if (directed_rows[i].reps > 1)
                    t.data_in = $urandom();
                idle_gap(1'b1);
                issue(t, directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // --- random traffic in bursts of biased mix ---
        burst_left = 0;
        gaps_on    = 1'b1;
        mix        = MIX_FILL;
        for (int n = 0; n < RANDOM_TXNS; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(20, 60);
                mix        = traffic_mix_t'($urandom_range(0, 2));
                gaps_on    = ($urandom_range(0, 3) != 0);
            end
            burst_left--;

            // let the pipe run dry once mid-run
            if (n == RANDOM_TXNS / 2)
            begin
                start <= 1'b0;
                while (pending_rsp.size() != 0)
                    @(posedge clk);
            end
            else
                idle_gap(gaps_on);

            t.mode    = pick_mode(mix);
            t.data_in = pick_word();
            if (ring_count != '0 && $urandom_range(0, 1))
                t.position = POS_W'($urandom_range(0, ring_count - 1));
            else
                t.position = POS_W'($urandom_range(0, QDEPTH - 1));
            issue(t, 1'b0, none);
        end

        // --- drain ---
        start  <= 1'b0;
        waited = 0;
        while (pending_rsp.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_rsp.size() != 0)
        begin
            $error("%0d transaction(s) never answered", pending_rsp.size());
            fail_count++;
        end
        // catch any stray strobe after the last response
        repeat (5) @(posedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
